[rtl/aew_pkg.sv]
// Shared types, constants and helper functions of the ambisonic encode weights block.
`timescale 1ns / 1ps

package aew_pkg;

    localparam int DIR_W   = 16;
    localparam int WGT_W   = 18;
    localparam int CHAN_W  = 4;
    localparam int N_CHAN  = 16;
    localparam int N_LANES = 12;
    localparam int PROD_W  = 32;
    localparam int LIN_W   = 34;
    localparam int NUM_W   = 49;
    localparam int MAG_W   = 48;
    localparam int QUO_W   = 22;
    localparam int RECIP_W = 23;

    typedef logic signed [DIR_W-1:0]  t_dir;
    typedef logic signed [WGT_W-1:0]  t_weight;
    typedef logic [CHAN_W-1:0]        t_chan;
    typedef logic [1:0]               t_order;
    typedef logic [1:0]               t_cfg_index;
    typedef logic [1:0]               t_cfg_data;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [LIN_W-1:0]  t_lin;
    typedef logic signed [NUM_W-1:0]  t_num;
    typedef logic [MAG_W-1:0]         t_mag;
    typedef logic [QUO_W-1:0]         t_quo;
    typedef logic [2:0]               t_gap;

    typedef struct packed {
        t_dir x;
        t_dir y;
        t_dir z;
    } t_dir_vec;

    typedef struct packed {
        logic   three_d;
        t_order order;
    } t_mode;

    typedef enum logic [1:0] {
        CFG_THREE_D_MODE   = 2'd0,
        CFG_HARMONIC_ORDER = 2'd1
    } t_cfg_reg;

    // channel positions in full 3D third-order order
    localparam t_chan CH_W = 4'd0;
    localparam t_chan CH_X = 4'd1;
    localparam t_chan CH_Y = 4'd2;
    localparam t_chan CH_U = 4'd3;
    localparam t_chan CH_V = 4'd4;
    localparam t_chan CH_P = 4'd5;
    localparam t_chan CH_Q = 4'd6;
    localparam t_chan CH_Z = 4'd7;
    localparam t_chan CH_S = 4'd8;
    localparam t_chan CH_T = 4'd9;
    localparam t_chan CH_R = 4'd10;
    localparam t_chan CH_N = 4'd11;
    localparam t_chan CH_O = 4'd12;
    localparam t_chan CH_L = 4'd13;
    localparam t_chan CH_M = 4'd14;
    localparam t_chan CH_K = 4'd15;

    // rounding lanes
    localparam int LN_U = 0;
    localparam int LN_V = 1;
    localparam int LN_P = 2;
    localparam int LN_Q = 3;
    localparam int LN_S = 4;
    localparam int LN_T = 5;
    localparam int LN_R = 6;
    localparam int LN_N = 7;
    localparam int LN_O = 8;
    localparam int LN_L = 9;
    localparam int LN_M = 10;
    localparam int LN_K = 11;

    localparam int LANE_SHIFT [N_LANES] = '{14, 13, 29, 29, 13, 13, 15, 30, 29, 26, 26, 30};
    localparam logic [N_LANES-1:0] LANE_DIV11 = 12'b0110_0000_0000;
    localparam t_chan LANE_CH [N_LANES] = '{CH_U, CH_V, CH_P, CH_Q, CH_S, CH_T,
                                            CH_R, CH_N, CH_O, CH_L, CH_M, CH_K};

    localparam t_weight W_WEIGHT = 18'sd46341;
    localparam t_weight WGT_MAX  = 18'sd131071;
    localparam t_weight WGT_MIN  = 18'sh2_0000;
    localparam t_quo    QUO_POS_SAT = 22'd131071;
    localparam t_quo    QUO_NEG_SAT = 22'd131072;

    localparam t_lin ONE_Q30 = 34'sd1073741824;

    // divide by 11: rounding half is 11 * 2^25, quotient via reciprocal 2^26 / 11
    localparam t_mag LDIV_HALF = 48'd369098752;
    localparam logic [RECIP_W-1:0] RECIP11 = 23'd6100806;
    localparam int RECIP11_SHIFT = 26;

    localparam t_gap GAP_FULL = 3'd7;

    function automatic t_mag lane_half(input int lane);
        t_mag h;
        if (LANE_DIV11[lane]) begin
            h = LDIV_HALF;
        end else begin
            h = t_mag'(1) << (LANE_SHIFT[lane] - 1);
        end
        return h;
    endfunction

    function automatic t_weight sat_weight(input logic neg, input t_quo q);
        t_weight w;
        if (neg) begin
            if (q >= QUO_NEG_SAT) begin
                w = WGT_MIN;
            end else begin
                w = -t_weight'(q);
            end
        end else begin
            if (q >= QUO_POS_SAT) begin
                w = WGT_MAX;
            end else begin
                w = t_weight'(q);
            end
        end
        return w;
    endfunction

    function automatic t_chan chan_last(input t_mode m);
        t_chan c;
        unique case (m.order)
            2'd0: c = 4'd0;
            2'd1: c = m.three_d ? 4'd3 : 4'd2;
            2'd2: c = m.three_d ? 4'd8 : 4'd4;
            2'd3: c = m.three_d ? 4'd15 : 4'd6;
            default: c = 4'd0;
        endcase
        return c;
    endfunction

endpackage

[rtl/aew_intf.sv]
// Handshake channel interfaces: direction input, weight output and register write.
`timescale 1ns / 1ps

interface aew_dir_if;
    logic          valid;
    logic          ready;
    aew_pkg::t_dir dir_x;
    aew_pkg::t_dir dir_y;
    aew_pkg::t_dir dir_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface aew_wgt_if;
    logic             valid;
    logic             ready;
    aew_pkg::t_chan   channel_index;
    aew_pkg::t_weight weight;
    logic             last_channel;

    modport source (output valid, output channel_index, output weight, output last_channel,
                    input ready);
    modport sink   (input valid, input channel_index, input weight, input last_channel,
                    output ready);
endinterface

interface aew_cfg_if;
    logic                valid;
    logic                ready;
    aew_pkg::t_cfg_index index;
    aew_pkg::t_cfg_data  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/ambisonic_encode_weights_top.sv]
// Top level of the third-order FuMa ambisonic encode weights block.
// Each direction passes through stages 1 to 7, the serializer and the output register.
// Throughput: weights leave one per cycle on the single result port while the receiver
// is ready, so a direction gives (order+1)^2 weights in 3D, 2*order+1 in 2D, one at
// order 0; the 7-stage pipeline takes a new item every cycle while it has room. Reset
// clears all valid bits and sets 3D mode, order 3.
`timescale 1ns / 1ps

module ambisonic_encode_weights_top (
    input logic        i_clk,
    input logic        i_rst_n,
    aew_dir_if.sink    i_dir,
    aew_cfg_if.sink    i_cfg,
    aew_wgt_if.source  o_wgt
);

    typedef logic signed [aew_pkg::NUM_W:0] t_wide;
    typedef logic [aew_pkg::QUO_W+aew_pkg::RECIP_W-1:0] t_rprod;

    // configuration
    logic            r_three_d;
    aew_pkg::t_order r_order;

    // pipeline control
    logic [7:1] r_vld;
    logic [8:1] w_rdy;

    // carried direction and mode
    aew_pkg::t_dir_vec r_dir  [1:6];
    aew_pkg::t_mode    r_mode [1:6];

    // stage 1: squares and cross products
    aew_pkg::t_prod n_s1_x2, n_s1_y2, n_s1_z2, n_s1_xy, n_s1_zx, n_s1_zy;
    aew_pkg::t_prod r_s1_x2, r_s1_y2, r_s1_z2, r_s1_xy, r_s1_zx, r_s1_zy;

    // stage 2: linear combinations
    aew_pkg::t_lin  n_s2_dxy, n_s2_pin, n_s2_qin, n_s2_pre, n_s2_kin, n_s2_rnum;
    aew_pkg::t_lin  r_s2_dxy, r_s2_pin, r_s2_qin, r_s2_pre, r_s2_kin, r_s2_rnum;
    aew_pkg::t_prod r_s2_xy, r_s2_zx, r_s2_zy;

    // stage 3: numerators
    aew_pkg::t_num n_s3_num [aew_pkg::N_LANES];
    aew_pkg::t_num r_s3_num [aew_pkg::N_LANES];
    t_wide         l_s3_p, l_s3_q, l_s3_n, l_s3_o, l_s3_l, l_s3_m, l_s3_k;

    // stage 4: sign and magnitude
    logic [aew_pkg::N_LANES-1:0] n_s4_neg, r_s4_neg;
    aew_pkg::t_mag n_s4_mag [aew_pkg::N_LANES];
    aew_pkg::t_mag r_s4_mag [aew_pkg::N_LANES];

    // stage 5: rounded shift
    logic [aew_pkg::N_LANES-1:0] r_s5_neg;
    aew_pkg::t_quo n_s5_quo [aew_pkg::N_LANES];
    aew_pkg::t_quo r_s5_quo [aew_pkg::N_LANES];

    // stage 6: divide by 11
    logic [aew_pkg::N_LANES-1:0] r_s6_neg;
    aew_pkg::t_quo n_s6_quo [aew_pkg::N_LANES];
    aew_pkg::t_quo r_s6_quo [aew_pkg::N_LANES];

    // stage 7: saturated weights
    aew_pkg::t_weight n_s7_w [aew_pkg::N_CHAN];
    aew_pkg::t_weight r_s7_w [aew_pkg::N_CHAN];
    aew_pkg::t_chan   n_s7_h, r_s7_h, n_s7_last, r_s7_last;
    aew_pkg::t_gap    n_s7_gap, r_s7_gap;

    // serializer
    logic             r_h_valid;
    aew_pkg::t_weight r_h_w [aew_pkg::N_CHAN];
    aew_pkg::t_chan   r_h_cnt, r_h_h, r_h_last, l_sel;
    aew_pkg::t_gap    r_h_gap;
    logic             w_h_fire, w_h_done;

    // output register
    logic             r_o_valid;
    aew_pkg::t_chan   r_o_chan;
    aew_pkg::t_weight r_o_weight;
    logic             r_o_last;
    logic             w_o_free;

    // handshake
    assign w_o_free = !r_o_valid || o_wgt.ready;
    assign w_h_fire = r_h_valid && w_o_free;
    assign w_h_done = w_h_fire && (r_h_cnt == r_h_last);

    always_comb begin
        w_rdy[8] = !r_h_valid || w_h_done;
        for (int k = 7; k >= 1; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign i_dir.ready = w_rdy[1];
    assign i_cfg.ready = 1'b1;

    // stage 1
    always_comb begin
        n_s1_x2 = i_dir.dir_x * i_dir.dir_x;
        n_s1_y2 = i_dir.dir_y * i_dir.dir_y;
        n_s1_z2 = i_dir.dir_z * i_dir.dir_z;
        n_s1_xy = i_dir.dir_x * i_dir.dir_y;
        n_s1_zx = i_dir.dir_z * i_dir.dir_x;
        n_s1_zy = i_dir.dir_z * i_dir.dir_y;
    end

    // stage 2
    always_comb begin
        aew_pkg::t_lin l_x2, l_y2, l_z2;
        l_x2 = aew_pkg::t_lin'(r_s1_x2);
        l_y2 = aew_pkg::t_lin'(r_s1_y2);
        l_z2 = aew_pkg::t_lin'(r_s1_z2);
        n_s2_dxy  = l_x2 - l_y2;
        n_s2_pin  = l_x2 - (l_y2 <<< 1) - l_y2;
        n_s2_qin  = (l_x2 <<< 1) + l_x2 - l_y2;
        n_s2_pre  = (l_z2 <<< 2) + l_z2 - aew_pkg::ONE_Q30;
        n_s2_kin  = (l_z2 <<< 2) + l_z2 - (aew_pkg::ONE_Q30 <<< 1) - aew_pkg::ONE_Q30;
        n_s2_rnum = (l_z2 <<< 1) + l_z2 - aew_pkg::ONE_Q30;
    end

    // stage 3
    always_comb begin
        l_s3_p = r_dir[2].x * r_s2_pin;
        l_s3_q = r_dir[2].y * r_s2_qin;
        l_s3_n = r_dir[2].z * r_s2_dxy;
        l_s3_o = r_s2_xy * r_dir[2].z;
        l_s3_l = r_dir[2].x * r_s2_pre;
        l_s3_m = r_dir[2].y * r_s2_pre;
        l_s3_k = r_dir[2].z * r_s2_kin;
        n_s3_num[aew_pkg::LN_U] = aew_pkg::t_num'(r_s2_dxy);
        n_s3_num[aew_pkg::LN_V] = aew_pkg::t_num'(r_s2_xy);
        n_s3_num[aew_pkg::LN_P] = aew_pkg::t_num'(l_s3_p);
        n_s3_num[aew_pkg::LN_Q] = aew_pkg::t_num'(l_s3_q);
        n_s3_num[aew_pkg::LN_S] = aew_pkg::t_num'(r_s2_zx);
        n_s3_num[aew_pkg::LN_T] = aew_pkg::t_num'(r_s2_zy);
        n_s3_num[aew_pkg::LN_R] = aew_pkg::t_num'(r_s2_rnum);
        n_s3_num[aew_pkg::LN_N] = aew_pkg::t_num'(l_s3_n);
        n_s3_num[aew_pkg::LN_O] = aew_pkg::t_num'(l_s3_o);
        n_s3_num[aew_pkg::LN_L] = aew_pkg::t_num'(l_s3_l);
        n_s3_num[aew_pkg::LN_M] = aew_pkg::t_num'(l_s3_m);
        n_s3_num[aew_pkg::LN_K] = aew_pkg::t_num'(l_s3_k);
    end

    // stages 4 to 6, one lane per weight that needs rounding
    always_comb begin
        for (int i = 0; i < aew_pkg::N_LANES; i++) begin
            n_s4_neg[i] = r_s3_num[i][aew_pkg::NUM_W-1];
            n_s4_mag[i] = aew_pkg::t_mag'(n_s4_neg[i] ? -r_s3_num[i] : r_s3_num[i]);
            n_s5_quo[i] = aew_pkg::t_quo'(({1'b0, r_s4_mag[i]} + {1'b0, aew_pkg::lane_half(i)})
                                          >> aew_pkg::LANE_SHIFT[i]);
            if (aew_pkg::LANE_DIV11[i]) begin
                n_s6_quo[i] = aew_pkg::t_quo'((t_rprod'(r_s5_quo[i]) * t_rprod'(aew_pkg::RECIP11))
                                              >> aew_pkg::RECIP11_SHIFT);
            end else begin
                n_s6_quo[i] = r_s5_quo[i];
            end
        end
    end

    // stage 7
    always_comb begin
        n_s7_w[aew_pkg::CH_W] = aew_pkg::W_WEIGHT;
        n_s7_w[aew_pkg::CH_X] = {r_dir[6].x[aew_pkg::DIR_W-1], r_dir[6].x, 1'b0};
        n_s7_w[aew_pkg::CH_Y] = {r_dir[6].y[aew_pkg::DIR_W-1], r_dir[6].y, 1'b0};
        n_s7_w[aew_pkg::CH_Z] = {r_dir[6].z[aew_pkg::DIR_W-1], r_dir[6].z, 1'b0};
        for (int i = 0; i < aew_pkg::N_LANES; i++) begin
            n_s7_w[aew_pkg::LANE_CH[i]] = aew_pkg::sat_weight(r_s6_neg[i], r_s6_quo[i]);
        end
        n_s7_h    = {1'b0, r_mode[6].order, 1'b1};
        n_s7_gap  = aew_pkg::GAP_FULL - n_s7_h[2:0];
        n_s7_last = aew_pkg::chan_last(r_mode[6]);
    end

    // height channels follow the horizontal ones at a fixed offset
    assign l_sel = r_h_cnt + ((r_h_cnt >= r_h_h) ? {1'b0, r_h_gap} : '0);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_three_d <= 1'b1;
            r_order   <= 2'd3;
            r_vld     <= '0;
            r_h_valid <= 1'b0;
            r_h_cnt   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    aew_pkg::CFG_THREE_D_MODE:   r_three_d <= i_cfg.data[0];
                    aew_pkg::CFG_HARMONIC_ORDER: r_order   <= i_cfg.data;
                    default: ;
                endcase
            end
            if (w_rdy[1]) r_vld[1] <= i_dir.valid;
            for (int k = 2; k <= 7; k++) begin
                if (w_rdy[k]) r_vld[k] <= r_vld[k-1];
            end
            priority if (w_rdy[8]) begin
                r_h_valid <= r_vld[7];
                r_h_cnt   <= '0;
            end else if (w_h_fire) begin
                r_h_cnt <= r_h_cnt + 1'b1;
            end else begin
                r_h_cnt <= r_h_cnt;
            end
            if (w_o_free) r_o_valid <= w_h_fire;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_dir[1]  <= '{x: i_dir.dir_x, y: i_dir.dir_y, z: i_dir.dir_z};
            r_mode[1] <= '{three_d: r_three_d, order: r_order};
            r_s1_x2   <= n_s1_x2;
            r_s1_y2   <= n_s1_y2;
            r_s1_z2   <= n_s1_z2;
            r_s1_xy   <= n_s1_xy;
            r_s1_zx   <= n_s1_zx;
            r_s1_zy   <= n_s1_zy;
        end
        for (int k = 2; k <= 6; k++) begin
            if (w_rdy[k]) begin
                r_dir[k]  <= r_dir[k-1];
                r_mode[k] <= r_mode[k-1];
            end
        end
        if (w_rdy[2]) begin
            r_s2_dxy  <= n_s2_dxy;
            r_s2_pin  <= n_s2_pin;
            r_s2_qin  <= n_s2_qin;
            r_s2_pre  <= n_s2_pre;
            r_s2_kin  <= n_s2_kin;
            r_s2_rnum <= n_s2_rnum;
            r_s2_xy   <= r_s1_xy;
            r_s2_zx   <= r_s1_zx;
            r_s2_zy   <= r_s1_zy;
        end
        if (w_rdy[3]) r_s3_num <= n_s3_num;
        if (w_rdy[4]) begin
            r_s4_neg <= n_s4_neg;
            r_s4_mag <= n_s4_mag;
        end
        if (w_rdy[5]) begin
            r_s5_neg <= r_s4_neg;
            r_s5_quo <= n_s5_quo;
        end
        if (w_rdy[6]) begin
            r_s6_neg <= r_s5_neg;
            r_s6_quo <= n_s6_quo;
        end
        if (w_rdy[7]) begin
            r_s7_w    <= n_s7_w;
            r_s7_h    <= n_s7_h;
            r_s7_gap  <= n_s7_gap;
            r_s7_last <= n_s7_last;
        end
        if (w_rdy[8] && r_vld[7]) begin
            r_h_w    <= r_s7_w;
            r_h_h    <= r_s7_h;
            r_h_gap  <= r_s7_gap;
            r_h_last <= r_s7_last;
        end
        if (w_h_fire) begin
            r_o_chan   <= r_h_cnt;
            r_o_weight <= r_h_w[l_sel];
            r_o_last   <= (r_h_cnt == r_h_last);
        end
    end

    assign o_wgt.valid         = r_o_valid;
    assign o_wgt.channel_index = r_o_chan;
    assign o_wgt.weight        = r_o_weight;
    assign o_wgt.last_channel  = r_o_last;

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_h_valid |-> (r_h_cnt <= r_h_last))
        else $error("serializer count beyond last channel");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_h_fire && (r_h_cnt != r_h_last))
            |=> (r_h_valid && (r_h_cnt == $past(r_h_cnt) + 1'b1)))
        else $error("serializer skipped or repeated a channel");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_h_done |=> (!r_h_valid || (r_h_cnt == '0)))
        else $error("new item does not start at channel zero");

    a_stage7_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[7] && !w_rdy[8]) |=> r_vld[7])
        else $error("stalled item dropped at last pipeline stage");

    a_first_is_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wgt.valid && (o_wgt.channel_index == aew_pkg::CH_W))
            |-> (o_wgt.weight == aew_pkg::W_WEIGHT))
        else $error("first channel is not the W weight");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the ambisonic encode weights block.
`timescale 1ns / 1ps

module tb_top;

    localparam int     PHASES    = 9;
    localparam int     RAND_PER  = 35;
    localparam int     LAT_TAIL  = 24;
    localparam int     HOLD_LEN  = 400;
    localparam int     LIMIT     = 1000000;
    localparam longint D14       = longint'(1) << 14;
    localparam longint D15       = longint'(1) << 15;
    localparam longint D29       = longint'(1) << 29;
    localparam longint Q30       = longint'(1) << 30;
    localparam aew_pkg::t_cfg_index CFG_SPARE_IDX = 2'd3;
    localparam aew_pkg::t_dir CORNERS [6] = '{16'sh0000, 16'sh0001, 16'shFFFF,
                                              16'sh7FFF, 16'sh8000, 16'sh8001};

    typedef struct {
        aew_pkg::t_chan   chan;
        aew_pkg::t_weight weight;
        logic             last;
    } t_weight_due;

    typedef struct {
        aew_pkg::t_cfg_index idx;
        aew_pkg::t_cfg_data  val;
    } t_reg_write;

    logic i_clk;
    logic i_rst_n;

    aew_dir_if dir_ch ();
    aew_cfg_if cfg_ch ();
    aew_wgt_if wgt_ch ();

    ambisonic_encode_weights_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dir   (dir_ch),
        .i_cfg   (cfg_ch),
        .o_wgt   (wgt_ch)
    );

    aew_pkg::t_dir_vec dir_queue [$];
    t_reg_write        cfg_queue [$];
    t_weight_due       weights_due [$];

    logic              mdl_three_d;
    aew_pkg::t_order   mdl_order;

    int                fail_count   = 0;
    int                dirs_done    = 0;
    int                weights_seen = 0;
    int                writes_done  = 0;
    int                cycle_count  = 0;
    int                dir_gap      = 0;
    int                sink_gap     = 0;
    bit                dir_idle_on  = 1'b1;
    bit                sink_idle_on = 1'b1;
    int                holds_asked  = 0;
    int                holds_served = 0;
    int                hold_left    = 0;
    aew_pkg::t_dir_vec dir_next;
    t_reg_write        cfg_next;
    t_weight_due       due;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // nearest Q2.16, ties away from zero, saturated
    function automatic aew_pkg::t_weight round_q16(input longint num, input longint den);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        if (num < 0) q = -q;
        if (q > longint'(aew_pkg::WGT_MAX)) q = longint'(aew_pkg::WGT_MAX);
        if (q < longint'(aew_pkg::WGT_MIN)) q = longint'(aew_pkg::WGT_MIN);
        return aew_pkg::t_weight'(q);
    endfunction

    function automatic void encode_dir(input aew_pkg::t_dir dx, input aew_pkg::t_dir dy,
                                       input aew_pkg::t_dir dz);
        longint x, y, z, x2, y2, z2, pre;
        aew_pkg::t_weight w [$];
        t_weight_due d;
        x = dx;
        y = dy;
        z = dz;
        x2 = x * x;
        y2 = y * y;
        z2 = z * z;
        w.insert(w.size(), aew_pkg::W_WEIGHT);
        if (mdl_order > 0) begin
            w.insert(w.size(), round_q16(2 * x, 1));
            w.insert(w.size(), round_q16(2 * y, 1));
            if (mdl_order > 1) begin
                w.insert(w.size(), round_q16(x2 - y2, D14));
                w.insert(w.size(), round_q16(2 * x * y, D14));
                if (mdl_order > 2) begin
                    w.insert(w.size(), round_q16(x * (x2 - 3 * y2), D29));
                    w.insert(w.size(), round_q16(y * (3 * x2 - y2), D29));
                end
            end
            if (mdl_three_d) begin
                w.insert(w.size(), round_q16(2 * z, 1));
                if (mdl_order > 1) begin
                    w.insert(w.size(), round_q16(2 * z * x, D14));
                    w.insert(w.size(), round_q16(2 * z * y, D14));
                    w.insert(w.size(), round_q16(3 * z2 - Q30, D15));
                    if (mdl_order > 2) begin
                        pre = 5 * z2 - Q30;
                        w.insert(w.size(), round_q16(z * (x2 - y2), Q30));
                        w.insert(w.size(), round_q16(x * y * z, D29));
                        w.insert(w.size(), round_q16(8 * x * pre, 11 * D29));
                        w.insert(w.size(), round_q16(8 * y * pre, 11 * D29));
                        w.insert(w.size(), round_q16(z * (5 * z2 - 3 * Q30), Q30));
                    end
                end
            end
        end
        foreach (w[k]) begin
            d.chan   = aew_pkg::t_chan'(k);
            d.weight = w[k];
            d.last   = (k == w.size() - 1);
            weights_due.insert(weights_due.size(), d);
        end
    endfunction

    task automatic queue_dir(input int x, input int y, input int z);
        aew_pkg::t_dir_vec v;
        v.x = aew_pkg::t_dir'(x);
        v.y = aew_pkg::t_dir'(y);
        v.z = aew_pkg::t_dir'(z);
        dir_queue.insert(dir_queue.size(), v);
    endtask

    task automatic queue_random(input int n);
        int  r;
        real az, el;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                az = $urandom_range(0, 62831) / 10000.0;
                el = $urandom_range(0, 31415) / 10000.0 - 1.5708;
                queue_dir($rtoi(32767.0 * $cos(el) * $cos(az)),
                          $rtoi(32767.0 * $cos(el) * $sin(az)),
                          $rtoi(32767.0 * $sin(el)));
            end else if (r < 80) begin
                queue_dir(int'($urandom() & 32'hFFFF) - 32768,
                          int'($urandom() & 32'hFFFF) - 32768,
                          int'($urandom() & 32'hFFFF) - 32768);
            end else begin
                queue_dir(CORNERS[$urandom_range(0, 5)], CORNERS[$urandom_range(0, 5)],
                          CORNERS[$urandom_range(0, 5)]);
            end
        end
    endtask

    task automatic wait_drained();
        while (dir_queue.size() != 0 || dir_ch.valid || weights_due.size() != 0)
            @(negedge i_clk);
        repeat (LAT_TAIL) @(negedge i_clk);
    endtask

    // direction driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dir_ch.valid <= 1'b0;
            dir_gap = 0;
        end else begin
            if (dir_ch.valid && dir_ch.ready) begin
                encode_dir(dir_ch.dir_x, dir_ch.dir_y, dir_ch.dir_z);
                dirs_done++;
            end
            if (!dir_ch.valid || dir_ch.ready) begin
                if (dir_gap > 0) begin
                    dir_gap--;
                    dir_ch.valid <= 1'b0;
                end else if (dir_queue.size() > 0) begin
                    dir_next = dir_queue.pop_front();
                    dir_ch.dir_x <= dir_next.x;
                    dir_ch.dir_y <= dir_next.y;
                    dir_ch.dir_z <= dir_next.z;
                    dir_ch.valid <= 1'b1;
                    dir_gap = dir_idle_on ? pick_idle() : 0;
                end else begin
                    dir_ch.valid <= 1'b0;
                end
            end
        end
    end

    // register write driver and register model
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_ch.valid <= 1'b0;
            mdl_three_d = 1'b1;
            mdl_order   = 2'd3;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    aew_pkg::CFG_THREE_D_MODE:   mdl_three_d = cfg_ch.data[0];
                    aew_pkg::CFG_HARMONIC_ORDER: mdl_order   = cfg_ch.data;
                    default: ;
                endcase
                writes_done++;
            end
            if (!cfg_ch.valid || cfg_ch.ready) begin
                if (cfg_queue.size() > 0) begin
                    cfg_next = cfg_queue.pop_front();
                    cfg_ch.index <= cfg_next.idx;
                    cfg_ch.data  <= cfg_next.val;
                    cfg_ch.valid <= 1'b1;
                end else begin
                    cfg_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            hold_left    <= HOLD_LEN;
            holds_served <= holds_served + 1;
        end
    end

    // weight monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wgt_ch.ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (wgt_ch.valid && wgt_ch.ready) begin
                if (weights_due.size() == 0) begin
                    $error("unexpected weight item: channel_index %0d weight %0d",
                           wgt_ch.channel_index, wgt_ch.weight);
                    fail_count++;
                end else begin
                    due = weights_due.pop_front();
                    if (wgt_ch.channel_index !== due.chan) begin
                        $error("channel_index: expected %0d, got %0d",
                               due.chan, wgt_ch.channel_index);
                        fail_count++;
                    end
                    if (wgt_ch.weight !== due.weight) begin
                        $error("weight: expected %0d, got %0d (channel %0d)",
                               due.weight, wgt_ch.weight, due.chan);
                        fail_count++;
                    end
                    if (wgt_ch.last_channel !== due.last) begin
                        $error("last_channel: expected %0d, got %0d (channel %0d)",
                               due.last, wgt_ch.last_channel, due.chan);
                        fail_count++;
                    end
                    weights_seen++;
                end
            end
            if (hold_left != 0) begin
                wgt_ch.ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                wgt_ch.ready <= 1'b0;
            end else begin
                wgt_ch.ready <= 1'b1;
                if (sink_idle_on && $urandom_range(0, 3) == 0) sink_gap = pick_idle();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        bit              ph_three_d [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
                                                 1'b1, 1'b1};
        aew_pkg::t_order ph_order   [PHASES] = '{2'd3, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2,
                                                 2'd3, 2'd3};
        t_reg_write      wr;

        i_rst_n      = 1'b0;
        dir_ch.valid = 1'b0;
        dir_ch.dir_x = '0;
        dir_ch.dir_y = '0;
        dir_ch.dir_z = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = aew_pkg::CFG_THREE_D_MODE;
        cfg_ch.data  = '0;
        wgt_ch.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed items at the reset setting (3D, third order)
        queue_dir(32767, 0, 0);
        queue_dir(-32768, 0, 0);
        queue_dir(0, 32767, 0);
        queue_dir(0, -32768, 0);
        queue_dir(0, 0, 32767);
        queue_dir(0, 0, -32768);
        queue_dir(0, 0, 0);
        queue_dir(32767, 32767, 32767);
        queue_dir(-32768, -32768, -32768);
        queue_dir(32767, -32768, 32767);
        queue_dir(-32768, 32767, -32768);
        queue_dir(23170, 23170, 0);
        queue_dir(18919, -18919, 18918);
        queue_dir(2049, 2047, 1);
        queue_dir(2047, 2049, -1);
        queue_dir(1, -1, 1);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            wr.idx = aew_pkg::CFG_THREE_D_MODE;
            wr.val = aew_pkg::t_cfg_data'({1'($urandom_range(0, 1)), ph_three_d[p]});
            cfg_queue.insert(cfg_queue.size(), wr);
            wr.idx = aew_pkg::CFG_HARMONIC_ORDER;
            wr.val = aew_pkg::t_cfg_data'(ph_order[p]);
            cfg_queue.insert(cfg_queue.size(), wr);
            if (p == PHASES - 2) begin
                wr.idx = CFG_SPARE_IDX;
                wr.val = aew_pkg::t_cfg_data'($urandom_range(0, 3));
                cfg_queue.insert(cfg_queue.size(), wr);
            end
            while (cfg_queue.size() != 0 || cfg_ch.valid) @(negedge i_clk);
            dir_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            if (p == PHASES - 1) begin
                dir_idle_on = 1'b0;
                holds_asked++;
            end
            queue_random(RAND_PER);
            wait_drained();
        end

        $display("Covered %0d directions and %0d weights with %0d register writes,",
                 dirs_done, weights_seen, writes_done);
        $display("over 2D and 3D sets at orders 0 to 3, including a long output stall.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
